@@ rtl/ffa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, constants and helpers of the first-fit allocator core.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // Arena geometry, fixed by the 10-bit offset fields
    localparam int ARENA_BYTES  = 512;
    localparam int HEADER_BYTES = 16;
    localparam int OFS_W        = 10;
    // Width of intermediate offset sums (start + header + size and more)
    localparam int SUM_W        = 12;
    // Size store depth: one record per payload offset 0..ARENA_BYTES
    localparam int STORE_DEPTH  = ARENA_BYTES + 1;

    // Result codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_IGNORED    = 2'd3
    } status_t;

    // One free extent: header offset and payload size
    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] size;
    } ext_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_F_SZ,
        S_F_RD,
        S_F_CHK,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    // Clamp a merged extent size to the arena length
    function automatic logic [OFS_W-1:0] cap_size(input logic [SUM_W-1:0] v);
        logic [OFS_W-1:0] r;
        if (v > SUM_W'(ARENA_BYTES)) begin
            r = OFS_W'(ARENA_BYTES);
        end else begin
            r = v[OFS_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/first_fit_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_core
// First-fit byte-arena allocator with an address-sorted free table.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser[0] selects allocate (0) or free (1); s_tdata
//   carries the request size and the payload offset to free. Every transfer
//   gives exactly one transfer on m_*: m_tuser holds the status code and
//   m_tdata the granted payload offset (0 unless an allocate succeeds).
//   One request is worked on at a time; s_tready is high only while idle.
//   The free table sits in a one-port-read memory and each entry visit
//   takes an address step and a check step. An allocate scans entries up
//   to the first fit; a whole-extent hit also moves the later entries down
//   to close the gap. A free looks up the size record, scans entries and
//   moves entries on insertion or on a merge that removes an entry. An
//   ignored free goes straight to its result. The sequencer passes through
//   idle after each result before the next request is taken.
//   Reset: aresetn low clears the sequencer; after release the arena-wide
//   extent is written into table entry 0 before the first request is taken.
//   Stall: a finished result waits in the output register while m_tready is
//   low; the next request is taken once that result is in the register.
// ----------------------------------------------------------------------------
module first_fit_allocator_core #(
    parameter int MAX_EXTENTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] request_size, [19:10] payload_offset
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] granted_offset
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IW  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW  = $clog2(MAX_EXTENTS + 1);
    localparam int OW  = ffa_pkg::OFS_W;
    localparam int SW  = ffa_pkg::SUM_W;
    localparam int BAW = $clog2(ffa_pkg::STORE_DEPTH);

    localparam logic [SW-1:0] HDR  = SW'(ffa_pkg::HEADER_BYTES);
    localparam logic [SW-1:0] HDR2 = SW'(2 * ffa_pkg::HEADER_BYTES);

    // Registers
    ffa_pkg::state_t  state_reg, state_next;
    logic [OW-1:0]    req_reg, req_next;
    logic [OW-1:0]    blk_reg, blk_next;
    logic [OW-1:0]    bsize_reg, bsize_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    k_reg, k_next;
    logic             up_reg, up_next;
    ffa_pkg::ext_t    prev_reg, prev_next;
    ffa_pkg::status_t status_reg, status_next;
    logic [OW-1:0]    grant_reg, grant_next;
    logic             mv_reg, mv_next;
    ffa_pkg::status_t ms_reg, ms_next;
    logic [OW-1:0]    mg_reg, mg_next;

    // Free table memory
    ffa_pkg::ext_t    tbl_mem [MAX_EXTENTS];
    ffa_pkg::ext_t    tbl_rdata;
    ffa_pkg::ext_t    tbl_wdata;
    logic             tbl_we;
    logic [CW-1:0]    tbl_waddr;
    logic [CW-1:0]    tbl_raddr;

    // Block size record memory
    logic [OW-1:0]    bs_mem [ffa_pkg::STORE_DEPTH];
    logic [OW-1:0]    bs_rdata;
    logic             bs_we;
    logic [BAW-1:0]   bs_waddr;
    logic [OW-1:0]    bs_wdata;
    logic [BAW-1:0]   bs_raddr;

    // Input fields
    logic             s_acc;
    logic             in_op;
    logic [OW-1:0]    in_req;
    logic [OW-1:0]    in_ofs;
    logic             in_bad;

    assign s_acc  = s_tvalid && s_tready;
    assign in_op  = s_tuser[0];
    assign in_req = s_tdata[9:0];
    assign in_ofs = s_tdata[19:10];
    assign in_bad = (in_ofs == '0) || (in_ofs < OW'(ffa_pkg::HEADER_BYTES))
                    || (in_ofs > OW'(ffa_pkg::ARENA_BYTES));

    // Allocate checks on the entry just read
    logic          a_fit, a_split;
    logic [OW-1:0] a_rest;
    logic [SW-1:0] a_pay_split, a_pay_whole;

    assign a_fit       = tbl_rdata.size >= req_reg;
    assign a_split     = SW'(tbl_rdata.size) > (SW'(req_reg) + HDR);
    assign a_rest      = OW'(SW'(tbl_rdata.size) - SW'(req_reg) - HDR);
    assign a_pay_split = SW'(tbl_rdata.start) + HDR2 + SW'(a_rest);
    assign a_pay_whole = SW'(tbl_rdata.start) + HDR;

    // Free merge decisions at the insertion point
    logic          cur_ok, scan_stop, with_prev, merge_both, with_next, tbl_full;
    logic          go_shift;
    logic [OW-1:0] np, npn, nn;

    assign cur_ok     = (state_reg == ffa_pkg::S_F_CHK);
    assign scan_stop  = ((state_reg == ffa_pkg::S_F_RD) && (idx_reg == cnt_reg))
                        || (cur_ok && !(tbl_rdata.start < blk_reg));
    assign with_prev  = (idx_reg != '0) &&
                        ((SW'(prev_reg.start) + HDR + SW'(prev_reg.size)) == SW'(blk_reg));
    assign np         = ffa_pkg::cap_size(SW'(prev_reg.size) + HDR + SW'(bsize_reg));
    assign merge_both = cur_ok &&
                        ((SW'(prev_reg.start) + HDR + SW'(np)) == SW'(tbl_rdata.start));
    assign npn        = ffa_pkg::cap_size(SW'(np) + HDR + SW'(tbl_rdata.size));
    assign with_next  = cur_ok &&
                        ((SW'(blk_reg) + HDR + SW'(bsize_reg)) == SW'(tbl_rdata.start));
    assign nn         = ffa_pkg::cap_size(SW'(bsize_reg) + HDR + SW'(tbl_rdata.size));
    assign tbl_full   = (cnt_reg >= CW'(MAX_EXTENTS));
    assign go_shift   = with_prev ? merge_both : (!with_next && !tbl_full);

    // Shift end conditions
    logic sh_end;
    assign sh_end = up_reg ? ((k_reg + CW'(1)) >= cnt_reg) : (k_reg == idx_reg);

    // Output register free to load
    logic m_free;
    assign m_free = !mv_reg || m_tready;

    // Memories
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr[IW-1:0]] <= tbl_wdata;
        end
        tbl_rdata <= tbl_mem[tbl_raddr[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (bs_we) begin
            bs_mem[bs_waddr] <= bs_wdata;
        end
        bs_rdata <= bs_mem[bs_raddr];
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffa_pkg::S_INIT;
            cnt_reg   <= CW'(1);
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        req_reg    <= req_next;
        blk_reg    <= blk_next;
        bsize_reg  <= bsize_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        up_reg     <= up_next;
        prev_reg   <= prev_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
        ms_reg     <= ms_next;
        mg_reg     <= mg_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffa_pkg::S_INIT: state_next = ffa_pkg::S_IDLE;
            ffa_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (!in_op) begin
                        state_next = ffa_pkg::S_A_RD;
                    end else if (in_bad) begin
                        state_next = ffa_pkg::S_DONE;
                    end else begin
                        state_next = ffa_pkg::S_F_SZ;
                    end
                end
            end
            ffa_pkg::S_A_RD: begin
                state_next = (idx_reg == cnt_reg) ? ffa_pkg::S_DONE : ffa_pkg::S_A_CHK;
            end
            ffa_pkg::S_A_CHK: begin
                if (!a_fit) begin
                    state_next = ffa_pkg::S_A_RD;
                end else if (a_split) begin
                    state_next = ffa_pkg::S_DONE;
                end else begin
                    state_next = ffa_pkg::S_SH_RD;
                end
            end
            ffa_pkg::S_F_SZ: state_next = ffa_pkg::S_F_RD;
            ffa_pkg::S_F_RD, ffa_pkg::S_F_CHK: begin
                if (scan_stop) begin
                    state_next = go_shift ? ffa_pkg::S_SH_RD : ffa_pkg::S_DONE;
                end else if (state_reg == ffa_pkg::S_F_RD) begin
                    state_next = ffa_pkg::S_F_CHK;
                end else begin
                    state_next = ffa_pkg::S_F_RD;
                end
            end
            ffa_pkg::S_SH_RD: begin
                state_next = sh_end ? ffa_pkg::S_DONE : ffa_pkg::S_SH_WR;
            end
            ffa_pkg::S_SH_WR: state_next = ffa_pkg::S_SH_RD;
            ffa_pkg::S_DONE: begin
                if (m_free) begin
                    state_next = ffa_pkg::S_IDLE;
                end
            end
            default: state_next = ffa_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory controls and result register
    always_comb begin
        req_next    = req_reg;
        blk_next    = blk_reg;
        bsize_next  = bsize_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        up_next     = up_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        mv_next     = mv_reg && !m_tready;
        ms_next     = ms_reg;
        mg_next     = mg_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = idx_reg;
        tbl_wdata   = tbl_rdata;
        tbl_raddr   = idx_reg;
        bs_we       = 1'b0;
        bs_waddr    = BAW'(in_ofs);
        bs_wdata    = req_reg;
        bs_raddr    = BAW'(in_ofs);
        s_tready    = 1'b0;

        unique case (state_reg)
            // Seed the table with one extent spanning the arena
            ffa_pkg::S_INIT: begin
                tbl_we    = 1'b1;
                tbl_waddr = '0;
                tbl_wdata = '{start: '0,
                    size: OW'(ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES)};
            end
            // Take a request
            ffa_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                req_next    = in_req;
                blk_next    = OW'(in_ofs - OW'(ffa_pkg::HEADER_BYTES));
                idx_next    = '0;
                grant_next  = '0;
                status_next = ffa_pkg::ST_OK;
                if (in_op && in_bad) begin
                    status_next = ffa_pkg::ST_IGNORED;
                end
            end
            ffa_pkg::S_A_RD: begin
                tbl_raddr = idx_reg;
                if (idx_reg == cnt_reg) begin
                    status_next = ffa_pkg::ST_NO_SPACE;
                end
            end
            // First fit: split from the tail or hand out the whole extent
            ffa_pkg::S_A_CHK: begin
                if (!a_fit) begin
                    idx_next = idx_reg + CW'(1);
                end else if (a_split) begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = idx_reg;
                    tbl_wdata  = '{start: tbl_rdata.start, size: a_rest};
                    grant_next = a_pay_split[OW-1:0];
                    bs_we      = (a_pay_split <= SW'(ffa_pkg::ARENA_BYTES));
                    bs_waddr   = a_pay_split[BAW-1:0];
                    bs_wdata   = req_reg;
                end else begin
                    grant_next = a_pay_whole[OW-1:0];
                    bs_we      = (a_pay_whole <= SW'(ffa_pkg::ARENA_BYTES));
                    bs_waddr   = a_pay_whole[BAW-1:0];
                    bs_wdata   = tbl_rdata.size;
                    k_next     = idx_reg;
                    up_next    = 1'b1;
                end
            end
            // Capture the recorded block size
            ffa_pkg::S_F_SZ: begin
                bsize_next = bs_rdata;
            end
            // Scan for the insertion point, then merge or insert
            ffa_pkg::S_F_RD, ffa_pkg::S_F_CHK: begin
                tbl_raddr = idx_reg;
                if (scan_stop) begin
                    if (with_prev) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = idx_reg - CW'(1);
                        tbl_wdata = '{start: prev_reg.start, size: merge_both ? npn : np};
                        k_next    = idx_reg;
                        up_next   = 1'b1;
                    end else if (with_next) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = idx_reg;
                        tbl_wdata = '{start: blk_reg, size: nn};
                    end else if (tbl_full) begin
                        status_next = ffa_pkg::ST_TABLE_FULL;
                    end else begin
                        k_next  = cnt_reg;
                        up_next = 1'b0;
                    end
                end else if (cur_ok) begin
                    prev_next = tbl_rdata;
                    idx_next  = idx_reg + CW'(1);
                end
            end
            // Move entries: down to close a gap, up to open one
            ffa_pkg::S_SH_RD: begin
                tbl_raddr = up_reg ? (k_reg + CW'(1)) : (k_reg - CW'(1));
                if (sh_end) begin
                    if (up_reg) begin
                        cnt_next = cnt_reg - CW'(1);
                    end else begin
                        tbl_we    = 1'b1;
                        tbl_waddr = idx_reg;
                        tbl_wdata = '{start: blk_reg, size: bsize_reg};
                        cnt_next  = cnt_reg + CW'(1);
                    end
                end
            end
            ffa_pkg::S_SH_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = k_reg;
                tbl_wdata = tbl_rdata;
                k_next    = up_reg ? (k_reg + CW'(1)) : (k_reg - CW'(1));
            end
            // Hand the result to the output register
            ffa_pkg::S_DONE: begin
                if (m_free) begin
                    mv_next = 1'b1;
                    ms_next = status_reg;
                    mg_next = (status_reg == ffa_pkg::ST_OK) ? grant_reg : '0;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = ms_reg;
    assign m_tdata  = {6'b0, mg_reg};

endmodule

@@ rtl/ffa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the first-fit allocator core, bound to the allocator core.
// ----------------------------------------------------------------------------
module ffa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // No result straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One request at a time: no transfer in the cycle after a transfer
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // A granted offset comes only with an ok status
    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata != 16'd0) |-> (m_tuser == ffa_pkg::ST_OK))
        else $error("offset granted with error status");

endmodule

bind first_fit_allocator_core ffa_checker u_ffa_checker (.*);
